@@ hdl/ihw_pkg.sv @@
// ----------------------------------------------------------------------------
// ihw_pkg
// Shared types, codes and helpers of the hex record writer: item and result
// structs, the command passed from front to back, and hex digit conversion.
// ----------------------------------------------------------------------------
package ihw_pkg;

    localparam int unsigned CNT_W = 6;

    localparam logic [1:0] MODE_SEGMENT = 2'd0;
    localparam logic [1:0] MODE_DATA    = 2'd1;
    localparam logic [1:0] MODE_ENTRY   = 2'd2;
    localparam logic [1:0] MODE_EOF     = 2'd3;

    localparam logic [7:0] TYPE_DATA  = 8'h00;
    localparam logic [7:0] TYPE_EOF   = 8'h01;
    localparam logic [7:0] TYPE_ELA   = 8'h04;
    localparam logic [7:0] TYPE_ENTRY = 8'h05;

    localparam logic [CNT_W-1:0] ELA_BYTES   = 6'd2;
    localparam logic [CNT_W-1:0] ENTRY_BYTES = 6'd4;

    localparam logic [6:0] ASCII_ZERO   = 7'h30;
    localparam logic [6:0] ASCII_LETTER = 7'h37;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [6:0] hex_high;
        logic [6:0] hex_low;
        logic       record_start;
        logic       record_end;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_ENTRY,
        TAIL_EOF
    } t_tail;

    typedef enum logic [1:0] {
        REC_ELA,
        REC_DATA,
        REC_ENTRY,
        REC_EOF
    } t_rec;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_COUNT,
        BK_AHI,
        BK_ALO,
        BK_TYPE,
        BK_DATA,
        BK_CHK
    } t_bk_state;

    typedef struct packed {
        logic             ela;
        logic             flush;
        logic [15:0]      upper;
        logic [15:0]      rec_offset;
        logic [CNT_W-1:0] count;
        logic             bank;
        t_tail            tail;
        logic [31:0]      ep_addr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
        logic [6:0] v;
        v = {3'b000, nib};
        if (nib < 4'd10) begin
            return ASCII_ZERO + v;
        end
        return ASCII_LETTER + v;
    endfunction

endpackage

@@ hdl/ihw_ram.sv @@
// ----------------------------------------------------------------------------
// ihw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ihw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ihw_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// ihw_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ihw_cmd_queue
    import ihw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

@@ hdl/ihw_front.sv @@
// ----------------------------------------------------------------------------
// ihw_front
// Accepts items, tracks the open record and the running address, writes data
// bytes into a ping-pong buffer and issues one command per item that emits.
// ----------------------------------------------------------------------------
module ihw_front
    import ihw_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  t_in                               i_in_item,
    input  logic                              i_q_full,
    output logic                              o_push,
    output t_cmd                              o_cmd,
    input  t_release                          i_release,
    output logic                              o_we,
    output logic [$clog2(2*RECORD_BYTES)-1:0] o_waddr,
    output logic [7:0]                        o_wdata
);

    localparam int unsigned MW = $clog2(RECORD_BYTES);
    localparam int unsigned AW = $clog2(2*RECORD_BYTES);
    localparam int unsigned RS = 32 + MW;
    // reciprocal of the record size, exact quotient for any 32-bit address
    localparam logic [32:0] RECIP =
        33'(((64'd1 << RS) + 64'(RECORD_BYTES) - 64'd1) / 64'(RECORD_BYTES));

    logic [CNT_W-1:0] r_fill,      n_fill;
    logic [31:0]      r_rec_addr,  n_rec_addr;
    logic [31:0]      r_next,      n_next;
    logic [15:0]      r_upper,     n_upper;
    logic             r_bank,      n_bank;
    logic [1:0]       r_busy,      n_busy;
    logic [MW-1:0]    r_mod,       n_mod;
    logic             r_rem_busy,  n_rem_busy;
    logic             r_rem_phase, n_rem_phase;
    logic [31:0]      r_rem_addr,  n_rem_addr;
    logic [31:0]      r_rem_q,     n_rem_q;

    logic             accept;
    logic             flush;
    logic [31:0]      rec_eff;
    logic [31:0]      next1;
    logic [MW-1:0]    mod1;
    logic [CNT_W-1:0] fill1;
    logic [64:0]      rem_prod;
    logic [31:0]      rem_quo;
    logic [MW-1:0]    rem_mod;

    assign o_in_ready = !r_rem_busy && !i_q_full && !r_busy[r_bank];
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        next1   = r_next + 32'd1;
        fill1   = r_fill + 6'd1;
        rec_eff = r_rec_addr;
        if (i_in_item.mode == MODE_DATA && r_fill == '0) begin
            rec_eff = r_next;
        end
        if (next1 == '0 || r_mod == MW'(RECORD_BYTES - 1)) begin
            mod1 = '0;
        end else begin
            mod1 = r_mod + MW'(1);
        end
        rem_prod = 65'(r_rem_addr) * 65'(RECIP);
        rem_quo  = 32'(rem_prod >> RS);
        rem_mod  = r_rem_addr[MW-1:0] - MW'(r_rem_q[MW-1:0] * MW'(RECORD_BYTES));
    end

    always_comb begin
        n_fill      = r_fill;
        n_rec_addr  = r_rec_addr;
        n_next      = r_next;
        n_upper     = r_upper;
        n_bank      = r_bank;
        n_busy      = r_busy;
        n_mod       = r_mod;
        n_rem_busy  = r_rem_busy;
        n_rem_phase = r_rem_phase;
        n_rem_addr  = r_rem_addr;
        n_rem_q     = r_rem_q;
        flush       = 1'b0;
        o_push      = 1'b0;
        o_we        = 1'b0;

        o_cmd.ela        = 1'b0;
        o_cmd.flush      = 1'b0;
        o_cmd.upper      = rec_eff[31:16];
        o_cmd.rec_offset = rec_eff[15:0];
        o_cmd.count      = r_fill;
        o_cmd.bank       = r_bank;
        o_cmd.tail       = TAIL_NONE;
        o_cmd.ep_addr    = i_in_item.address;

        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (r_rem_busy) begin
            if (!r_rem_phase) begin
                n_rem_q     = rem_quo;
                n_rem_phase = 1'b1;
            end else begin
                n_mod      = rem_mod;
                n_rem_busy = 1'b0;
            end
        end

        if (accept) begin
            unique case (i_in_item.mode)
                MODE_SEGMENT: begin
                    flush       = (r_fill != '0);
                    n_next      = i_in_item.address;
                    n_rec_addr  = i_in_item.address;
                    n_mod       = '0;
                    n_rem_addr  = i_in_item.address;
                    n_rem_phase = 1'b0;
                    n_rem_busy  = 1'b1;
                end
                MODE_DATA: begin
                    o_we        = 1'b1;
                    o_cmd.count = fill1;
                    n_fill      = fill1;
                    n_rec_addr  = rec_eff;
                    n_next      = next1;
                    n_mod       = mod1;
                    flush = (mod1 == '0) || (next1[15:0] == '0)
                        || (fill1 >= CNT_W'(RECORD_BYTES));
                end
                MODE_ENTRY: begin
                    flush      = (r_fill != '0);
                    o_cmd.tail = TAIL_ENTRY;
                end
                MODE_EOF: begin
                    flush      = (r_fill != '0);
                    o_cmd.tail = TAIL_EOF;
                end
            endcase

            o_cmd.flush = flush;
            o_cmd.ela   = flush && (rec_eff[31:16] != r_upper);
            o_push      = flush || (o_cmd.tail != TAIL_NONE);
            if (flush) begin
                n_upper        = rec_eff[31:16];
                n_fill         = '0;
                n_bank         = ~r_bank;
                n_busy[r_bank] = 1'b1;
            end
            if (i_in_item.mode == MODE_EOF) begin
                n_fill     = '0;
                n_rec_addr = '0;
                n_next     = '0;
                n_upper    = '0;
                n_mod      = '0;
            end
        end
    end

    assign o_wdata = i_in_item.data_byte;
    assign o_waddr = r_bank ? AW'(RECORD_BYTES) + AW'(r_fill) : AW'(r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rec_addr  <= '0;
            r_next      <= '0;
            r_upper     <= '0;
            r_bank      <= 1'b0;
            r_busy      <= '0;
            r_mod       <= '0;
            r_rem_busy  <= 1'b0;
            r_rem_phase <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_rec_addr  <= n_rec_addr;
            r_next      <= n_next;
            r_upper     <= n_upper;
            r_bank      <= n_bank;
            r_busy      <= n_busy;
            r_mod       <= n_mod;
            r_rem_busy  <= n_rem_busy;
            r_rem_phase <= n_rem_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_addr <= n_rem_addr;
        r_rem_q    <= n_rem_q;
    end

endmodule

@@ hdl/ihw_back.sv @@
// ----------------------------------------------------------------------------
// ihw_back
// Record sequencer: walks the records of one command byte by byte, keeps the
// running checksum and drives the registered result port.
// ----------------------------------------------------------------------------
module ihw_back
    import ihw_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cmd                              i_head,
    input  logic                              i_head_valid,
    output logic                              o_pop,
    output logic [$clog2(2*RECORD_BYTES)-1:0] o_raddr,
    input  logic [7:0]                        i_rdata,
    output t_release                          o_release,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output t_out                              o_out_item
);

    localparam int unsigned AW = $clog2(2*RECORD_BYTES);

    t_bk_state        r_state, n_state;
    t_rec             r_rec,   n_rec;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic [7:0]       r_sum,   n_sum;
    logic             r_out_valid;
    t_out             r_out;

    logic             step;
    logic             has_next;
    t_rec             next_rec;
    logic [CNT_W-1:0] rec_count;
    logic [15:0]      rec_addr;
    logic [7:0]       rec_type;
    logic [7:0]       fixed_byte;
    logic [7:0]       cur_byte;
    logic             cur_start;
    logic             cur_end;
    logic             cur_last;
    logic [AW-1:0]    idx_low;
    t_rec             tail_rec;

    assign step = (r_state != BK_IDLE) && (!r_out_valid || i_out_ready);

    always_comb begin
        tail_rec = (i_head.tail == TAIL_ENTRY) ? REC_ENTRY : REC_EOF;
        has_next = 1'b0;
        next_rec = tail_rec;
        unique case (r_rec)
            REC_ELA: begin
                if (i_head.flush) begin
                    has_next = 1'b1;
                    next_rec = REC_DATA;
                end else begin
                    has_next = (i_head.tail != TAIL_NONE);
                end
            end
            REC_DATA:  has_next = (i_head.tail != TAIL_NONE);
            REC_ENTRY: has_next = 1'b0;
            REC_EOF:   has_next = 1'b0;
        endcase

        unique case (r_rec)
            REC_ELA: begin
                rec_count  = ELA_BYTES;
                rec_type   = TYPE_ELA;
                fixed_byte = r_idx[0] ? i_head.upper[7:0] : i_head.upper[15:8];
            end
            REC_DATA: begin
                rec_count  = i_head.count;
                rec_type   = TYPE_DATA;
                fixed_byte = i_rdata;
            end
            REC_ENTRY: begin
                rec_count = ENTRY_BYTES;
                rec_type  = TYPE_ENTRY;
                unique case (r_idx[1:0])
                    2'd0: fixed_byte = i_head.ep_addr[31:24];
                    2'd1: fixed_byte = i_head.ep_addr[23:16];
                    2'd2: fixed_byte = i_head.ep_addr[15:8];
                    2'd3: fixed_byte = i_head.ep_addr[7:0];
                endcase
            end
            REC_EOF: begin
                rec_count  = '0;
                rec_type   = TYPE_EOF;
                fixed_byte = '0;
            end
        endcase
        rec_addr = (r_rec == REC_DATA) ? i_head.rec_offset : 16'h0000;
    end

    // byte and flags of the current step
    always_comb begin
        cur_byte  = '0;
        cur_start = 1'b0;
        cur_end   = 1'b0;
        cur_last  = 1'b0;
        unique case (r_state)
            BK_IDLE:  cur_byte = '0;
            BK_COUNT: begin
                cur_byte  = {2'b00, rec_count};
                cur_start = 1'b1;
            end
            BK_AHI:   cur_byte = rec_addr[15:8];
            BK_ALO:   cur_byte = rec_addr[7:0];
            BK_TYPE:  cur_byte = rec_type;
            BK_DATA:  cur_byte = fixed_byte;
            BK_CHK: begin
                cur_byte = 8'h00 - r_sum;
                cur_end  = 1'b1;
                cur_last = !has_next;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_rec   = r_rec;
        n_idx   = r_idx;
        n_sum   = r_sum;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head_valid) begin
                    n_state = BK_COUNT;
                    n_idx   = '0;
                    n_sum   = '0;
                    if (i_head.ela) begin
                        n_rec = REC_ELA;
                    end else if (i_head.flush) begin
                        n_rec = REC_DATA;
                    end else begin
                        n_rec = tail_rec;
                    end
                end
            end
            BK_COUNT: if (step) begin
                n_state = BK_AHI;
                n_sum   = r_sum + cur_byte;
            end
            BK_AHI: if (step) begin
                n_state = BK_ALO;
                n_sum   = r_sum + cur_byte;
            end
            BK_ALO: if (step) begin
                n_state = BK_TYPE;
                n_sum   = r_sum + cur_byte;
            end
            BK_TYPE: if (step) begin
                n_state = (rec_count == '0) ? BK_CHK : BK_DATA;
                n_sum   = r_sum + cur_byte;
            end
            BK_DATA: if (step) begin
                n_idx = r_idx + 6'd1;
                n_sum = r_sum + cur_byte;
                if (r_idx + 6'd1 == rec_count) begin
                    n_state = BK_CHK;
                end
            end
            BK_CHK: if (step) begin
                if (has_next) begin
                    n_state = BK_COUNT;
                    n_rec   = next_rec;
                    n_idx   = '0;
                    n_sum   = '0;
                end else begin
                    n_state = BK_IDLE;
                    o_pop   = 1'b1;
                end
            end
        endcase
    end

    // read address follows the next index so read data tracks r_idx
    always_comb begin
        idx_low = '0;
        if (n_idx < CNT_W'(RECORD_BYTES)) begin
            idx_low = AW'(n_idx);
        end
        o_raddr = i_head.bank ? AW'(RECORD_BYTES) + idx_low : idx_low;
    end

    assign o_release.valid = step && (r_state == BK_CHK) && (r_rec == REC_DATA);
    assign o_release.bank  = i_head.bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_rec       <= REC_ELA;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rec   <= n_rec;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.hex_high     <= hex_ascii(cur_byte[7:4]);
            r_out.hex_low      <= hex_ascii(cur_byte[3:0]);
            r_out.record_start <= cur_start;
            r_out.record_end   <= cur_end;
            r_out.last         <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ hdl/intel_hex_record_writer_unit.sv @@
// Path: a record-closing item's command passes the command queue, the back's
// state register and its result register before its first result shows.
// Throughput: one result per cycle from the back while i_out_ready allows; a record
// of n data bytes gives n + 5 result bytes, and each command begins with an idle dispatch step.
// A segment start holds the front busy while a reciprocal multiply works out the address remainder.
// Reset: synchronous, active low; clears all control state, not the buffer.
// ----------------------------------------------------------------------------
// intel_hex_record_writer_unit
// Binary byte stream to hex records: front tracks records and fills a
// ping-pong buffer, back emits record bytes through a command queue.
// ----------------------------------------------------------------------------
module intel_hex_record_writer_unit
    import ihw_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    localparam int unsigned AW = $clog2(2*RECORD_BYTES);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    t_cmd          q_cmd;
    t_cmd          q_head;
    t_release      release_bank;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    ihw_front #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_cmd),
        .i_release  (release_bank),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata)
    );

    ihw_ram #(
        .WIDTH(8),
        .DEPTH(2*RECORD_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ihw_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ihw_back #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (!q_empty),
        .o_pop        (q_pop),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_release    (release_bank),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

@@ hdl/ihw_checker.sv @@
// ----------------------------------------------------------------------------
// ihw_checker
// Port-level checks on the result stream of the hex record writer.
// ----------------------------------------------------------------------------
module ihw_checker
    import ihw_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_hex_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_item.hex_high >= 7'h30 && o_out_item.hex_high <= 7'h39) ||
             (o_out_item.hex_high >= 7'h41 && o_out_item.hex_high <= 7'h46)) &&
            ((o_out_item.hex_low >= 7'h30 && o_out_item.hex_low <= 7'h39) ||
             (o_out_item.hex_low >= 7'h41 && o_out_item.hex_low <= 7'h46)))
        else $error("result digit is not an upper-case hex character");

    a_start_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.record_start && o_out_item.record_end))
        else $error("byte marked as both record start and checksum");

    a_last_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> o_out_item.record_end)
        else $error("last result is not a checksum byte");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind intel_hex_record_writer_unit ihw_checker u_checker (.*);
